>>> rtl/core/c8arf_pkg.sv
// Shared types, operation codes and flag positions for the 8-bit ALU execute stage.
package c8arf_pkg;

    localparam int unsigned FuncWidth = 6;

    // Operation codes
    localparam logic [FuncWidth-1:0] OP_ADC = 6'd0;
    localparam logic [FuncWidth-1:0] OP_SBC = 6'd1;
    localparam logic [FuncWidth-1:0] OP_AND = 6'd2;
    localparam logic [FuncWidth-1:0] OP_ORA = 6'd3;
    localparam logic [FuncWidth-1:0] OP_EOR = 6'd4;
    localparam logic [FuncWidth-1:0] OP_ASL = 6'd5;
    localparam logic [FuncWidth-1:0] OP_LSR = 6'd6;
    localparam logic [FuncWidth-1:0] OP_ROL = 6'd7;
    localparam logic [FuncWidth-1:0] OP_ROR = 6'd8;
    localparam logic [FuncWidth-1:0] OP_INC = 6'd9;
    localparam logic [FuncWidth-1:0] OP_DEC = 6'd10;
    localparam logic [FuncWidth-1:0] OP_INX = 6'd11;
    localparam logic [FuncWidth-1:0] OP_INY = 6'd12;
    localparam logic [FuncWidth-1:0] OP_DEX = 6'd13;
    localparam logic [FuncWidth-1:0] OP_DEY = 6'd14;
    localparam logic [FuncWidth-1:0] OP_CMP = 6'd15;
    localparam logic [FuncWidth-1:0] OP_CPX = 6'd16;
    localparam logic [FuncWidth-1:0] OP_CPY = 6'd17;
    localparam logic [FuncWidth-1:0] OP_BIT = 6'd18;
    localparam logic [FuncWidth-1:0] OP_LDA = 6'd19;
    localparam logic [FuncWidth-1:0] OP_LDX = 6'd20;
    localparam logic [FuncWidth-1:0] OP_LDY = 6'd21;
    localparam logic [FuncWidth-1:0] OP_STA = 6'd22;
    localparam logic [FuncWidth-1:0] OP_STX = 6'd23;
    localparam logic [FuncWidth-1:0] OP_STY = 6'd24;
    localparam logic [FuncWidth-1:0] OP_TAX = 6'd25;
    localparam logic [FuncWidth-1:0] OP_TAY = 6'd26;
    localparam logic [FuncWidth-1:0] OP_TXA = 6'd27;
    localparam logic [FuncWidth-1:0] OP_TYA = 6'd28;
    localparam logic [FuncWidth-1:0] OP_TSX = 6'd29;
    localparam logic [FuncWidth-1:0] OP_TXS = 6'd30;
    localparam logic [FuncWidth-1:0] OP_CLC = 6'd31;
    localparam logic [FuncWidth-1:0] OP_CLD = 6'd32;
    localparam logic [FuncWidth-1:0] OP_CLI = 6'd33;
    localparam logic [FuncWidth-1:0] OP_CLV = 6'd34;
    localparam logic [FuncWidth-1:0] OP_SEC = 6'd35;
    localparam logic [FuncWidth-1:0] OP_SED = 6'd36;
    localparam logic [FuncWidth-1:0] OP_SEI = 6'd37;
    localparam logic [FuncWidth-1:0] OP_BCC = 6'd38;
    localparam logic [FuncWidth-1:0] OP_BCS = 6'd39;
    localparam logic [FuncWidth-1:0] OP_BEQ = 6'd40;
    localparam logic [FuncWidth-1:0] OP_BMI = 6'd41;
    localparam logic [FuncWidth-1:0] OP_BNE = 6'd42;
    localparam logic [FuncWidth-1:0] OP_BPL = 6'd43;
    localparam logic [FuncWidth-1:0] OP_BVC = 6'd44;
    localparam logic [FuncWidth-1:0] OP_BVS = 6'd45;
    localparam logic [FuncWidth-1:0] OP_NOP = 6'd46;

    // Status bit positions
    localparam int unsigned FLAG_C = 0;
    localparam int unsigned FLAG_Z = 1;
    localparam int unsigned FLAG_I = 2;
    localparam int unsigned FLAG_D = 3;
    localparam int unsigned FLAG_V = 6;
    localparam int unsigned FLAG_N = 7;

    typedef struct packed {
        logic [FuncWidth-1:0] func;
        logic [7:0]           operand;
        logic                 on_accumulator;
    } req_t;

    typedef struct packed {
        logic       write_enable;
        logic [7:0] write_data;
        logic       branch_taken;
        logic [7:0] status_out;
    } rsp_t;

endpackage

>>> rtl/core/cpu8_alu_register_flags.sv
// Each request passes through the input register, then the result register, before its result
// is offered on the result handshake.
// Throughput: one request per cycle; ready drops only while the result register is stalled.
// The architectural registers (A, X, Y, SP, P) update as a request moves into the result register,
// so the next request in the input register always sees the state left by the one before it.
// Reset: aresetn is synchronous, active low; it clears A, X, Y, SP, P and both valid flags.
module cpu8_alu_register_flags (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  c8arf_pkg::req_t   s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output c8arf_pkg::rsp_t   m_data
);

    // Input register: holds the accepted request until the execute logic consumes it
    logic             in_vld_reg;
    c8arf_pkg::req_t  in_reg;

    // Result register
    logic             out_vld_reg;
    c8arf_pkg::rsp_t  out_reg;
    c8arf_pkg::rsp_t  out_next;

    // Architectural state
    logic [7:0] acc_reg,   acc_next;
    logic [7:0] x_reg,     x_next;
    logic [7:0] y_reg,     y_next;
    logic [7:0] sp_reg,    sp_next;
    logic [7:0] p_reg,     p_next;

    logic advance;

    // Advance when the result slot is free or is being drained this cycle
    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;
    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

    // Execute: one pass of 8-bit arithmetic, logic and flag work
    always_comb begin
        logic [7:0] m;
        logic [7:0] m_eff;
        logic [8:0] sum;
        logic [7:0] res;
        logic [7:0] cmp_src;
        logic [8:0] diff;
        logic [7:0] sh_src;
        logic [7:0] sh_res;
        logic       sh_cout;
        logic       cin;

        m        = in_reg.operand;
        cin      = p_reg[c8arf_pkg::FLAG_C];
        acc_next = acc_reg;
        x_next   = x_reg;
        y_next   = y_reg;
        sp_next  = sp_reg;
        p_next   = p_reg;
        out_next = '0;

        // Adder shared by ADC and SBC (SBC adds the inverted operand)
        m_eff = (in_reg.func == c8arf_pkg::OP_SBC) ? ~m : m;
        sum   = {1'b0, acc_reg} + {1'b0, m_eff} + {8'b0, cin};

        // Comparator source register
        unique case (in_reg.func)
            c8arf_pkg::OP_CPX: cmp_src = x_reg;
            c8arf_pkg::OP_CPY: cmp_src = y_reg;
            default:           cmp_src = acc_reg;
        endcase
        diff = {1'b0, cmp_src} - {1'b0, m};

        // Shifter
        sh_src = in_reg.on_accumulator ? acc_reg : m;
        unique case (in_reg.func)
            c8arf_pkg::OP_ASL: begin
                sh_cout = sh_src[7];
                sh_res  = {sh_src[6:0], 1'b0};
            end
            c8arf_pkg::OP_ROL: begin
                sh_cout = sh_src[7];
                sh_res  = {sh_src[6:0], cin};
            end
            c8arf_pkg::OP_ROR: begin
                sh_cout = sh_src[0];
                sh_res  = {cin, sh_src[7:1]};
            end
            default: begin
                sh_cout = sh_src[0];
                sh_res  = {1'b0, sh_src[7:1]};
            end
        endcase

        res = 8'h00;

        unique case (in_reg.func)
            c8arf_pkg::OP_ADC, c8arf_pkg::OP_SBC: begin
                res = sum[7:0];
                acc_next = res;
                p_next[c8arf_pkg::FLAG_C] = sum[8];
                p_next[c8arf_pkg::FLAG_V] = (acc_reg[7] ^ res[7]) & (m_eff[7] ^ res[7]);
            end
            c8arf_pkg::OP_AND: begin res = acc_reg & m; acc_next = res; end
            c8arf_pkg::OP_ORA: begin res = acc_reg | m; acc_next = res; end
            c8arf_pkg::OP_EOR: begin res = acc_reg ^ m; acc_next = res; end
            c8arf_pkg::OP_ASL, c8arf_pkg::OP_LSR,
            c8arf_pkg::OP_ROL, c8arf_pkg::OP_ROR: begin
                res = sh_res;
                p_next[c8arf_pkg::FLAG_C] = sh_cout;
                if (in_reg.on_accumulator) begin
                    acc_next = res;
                end else begin
                    out_next.write_enable = 1'b1;
                    out_next.write_data   = res;
                end
            end
            c8arf_pkg::OP_INC: begin
                res = m + 8'h01;
                out_next.write_enable = 1'b1;
                out_next.write_data   = res;
            end
            c8arf_pkg::OP_DEC: begin
                res = m - 8'h01;
                out_next.write_enable = 1'b1;
                out_next.write_data   = res;
            end
            c8arf_pkg::OP_INX: begin res = x_reg + 8'h01; x_next = res; end
            c8arf_pkg::OP_INY: begin res = y_reg + 8'h01; y_next = res; end
            c8arf_pkg::OP_DEX: begin res = x_reg - 8'h01; x_next = res; end
            c8arf_pkg::OP_DEY: begin res = y_reg - 8'h01; y_next = res; end
            c8arf_pkg::OP_CMP, c8arf_pkg::OP_CPX, c8arf_pkg::OP_CPY: begin
                res = diff[7:0];
                p_next[c8arf_pkg::FLAG_C] = ~diff[8];
            end
            c8arf_pkg::OP_BIT: begin
                p_next[c8arf_pkg::FLAG_Z] = ((acc_reg & m) == 8'h00);
                p_next[c8arf_pkg::FLAG_N] = m[7];
                p_next[c8arf_pkg::FLAG_V] = m[6];
            end
            c8arf_pkg::OP_LDA: begin res = m; acc_next = m; end
            c8arf_pkg::OP_LDX: begin res = m; x_next = m; end
            c8arf_pkg::OP_LDY: begin res = m; y_next = m; end
            c8arf_pkg::OP_STA: begin
                out_next.write_enable = 1'b1;
                out_next.write_data   = acc_reg;
            end
            c8arf_pkg::OP_STX: begin
                out_next.write_enable = 1'b1;
                out_next.write_data   = x_reg;
            end
            c8arf_pkg::OP_STY: begin
                out_next.write_enable = 1'b1;
                out_next.write_data   = y_reg;
            end
            c8arf_pkg::OP_TAX: begin res = acc_reg; x_next = res; end
            c8arf_pkg::OP_TAY: begin res = acc_reg; y_next = res; end
            c8arf_pkg::OP_TXA: begin res = x_reg; acc_next = res; end
            c8arf_pkg::OP_TYA: begin res = y_reg; acc_next = res; end
            c8arf_pkg::OP_TSX: begin res = sp_reg; x_next = res; end
            c8arf_pkg::OP_TXS: sp_next = x_reg;
            c8arf_pkg::OP_CLC: p_next[c8arf_pkg::FLAG_C] = 1'b0;
            c8arf_pkg::OP_CLD: p_next[c8arf_pkg::FLAG_D] = 1'b0;
            c8arf_pkg::OP_CLI: p_next[c8arf_pkg::FLAG_I] = 1'b0;
            c8arf_pkg::OP_CLV: p_next[c8arf_pkg::FLAG_V] = 1'b0;
            c8arf_pkg::OP_SEC: p_next[c8arf_pkg::FLAG_C] = 1'b1;
            c8arf_pkg::OP_SED: p_next[c8arf_pkg::FLAG_D] = 1'b1;
            c8arf_pkg::OP_SEI: p_next[c8arf_pkg::FLAG_I] = 1'b1;
            c8arf_pkg::OP_BCC: out_next.branch_taken = ~p_reg[c8arf_pkg::FLAG_C];
            c8arf_pkg::OP_BCS: out_next.branch_taken =  p_reg[c8arf_pkg::FLAG_C];
            c8arf_pkg::OP_BEQ: out_next.branch_taken =  p_reg[c8arf_pkg::FLAG_Z];
            c8arf_pkg::OP_BMI: out_next.branch_taken =  p_reg[c8arf_pkg::FLAG_N];
            c8arf_pkg::OP_BNE: out_next.branch_taken = ~p_reg[c8arf_pkg::FLAG_Z];
            c8arf_pkg::OP_BPL: out_next.branch_taken = ~p_reg[c8arf_pkg::FLAG_N];
            c8arf_pkg::OP_BVC: out_next.branch_taken = ~p_reg[c8arf_pkg::FLAG_V];
            c8arf_pkg::OP_BVS: out_next.branch_taken =  p_reg[c8arf_pkg::FLAG_V];
            default: ; // NOP and unused codes
        endcase

        // Update N and Z from the result for every operation that sets them from it (BIT sets them above)
        unique case (in_reg.func)
            c8arf_pkg::OP_ADC, c8arf_pkg::OP_SBC, c8arf_pkg::OP_AND, c8arf_pkg::OP_ORA,
            c8arf_pkg::OP_EOR, c8arf_pkg::OP_ASL, c8arf_pkg::OP_LSR, c8arf_pkg::OP_ROL,
            c8arf_pkg::OP_ROR, c8arf_pkg::OP_INC, c8arf_pkg::OP_DEC, c8arf_pkg::OP_INX,
            c8arf_pkg::OP_INY, c8arf_pkg::OP_DEX, c8arf_pkg::OP_DEY, c8arf_pkg::OP_CMP,
            c8arf_pkg::OP_CPX, c8arf_pkg::OP_CPY, c8arf_pkg::OP_LDA, c8arf_pkg::OP_LDX,
            c8arf_pkg::OP_LDY, c8arf_pkg::OP_TAX, c8arf_pkg::OP_TAY, c8arf_pkg::OP_TXA,
            c8arf_pkg::OP_TYA, c8arf_pkg::OP_TSX: begin
                p_next[c8arf_pkg::FLAG_N] = res[7];
                p_next[c8arf_pkg::FLAG_Z] = (res == 8'h00);
            end
            default: ;
        endcase

        out_next.status_out = p_next;
    end

    // Control and architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            acc_reg     <= 8'h00;
            x_reg       <= 8'h00;
            y_reg       <= 8'h00;
            sp_reg      <= 8'h00;
            p_reg       <= 8'h00;
        end else begin
            // Hold the input register unless it drains; refill on acceptance
            if (s_valid && s_ready) begin
                in_vld_reg <= 1'b1;
            end else if (advance) begin
                in_vld_reg <= 1'b0;
            end
            // Drop the result once taken; load a new one on advance
            if (advance) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
            // Commit architectural state with the result
            if (advance) begin
                acc_reg <= acc_next;
                x_reg   <= x_next;
                y_reg   <= y_next;
                sp_reg  <= sp_next;
                p_reg   <= p_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg <= out_next;
        end
    end

    // Status bits 5 and 4 are never written
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.status_out[5:4] == 2'b00))
        else $error("unused status bits set");

    // A branch never writes memory
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.branch_taken) |-> !m_data.write_enable)
        else $error("branch with memory write");

    // Write data is zero whenever no write is requested
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.write_enable) |-> (m_data.write_data == 8'h00))
        else $error("stray write data");

    // The result register reports what the state registers hold
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(advance) |-> (m_data.status_out == p_reg))
        else $error("status out of step with flags");

endmodule

>>> tb/sv/cpu8_alu_register_flags_tb.sv
// Self-checking testbench for the 8-bit ALU execute stage with a shadow copy of A, X, Y, SP and P.
module cpu8_alu_register_flags_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import c8arf_pkg::*;

    // Spare function codes above NOP must behave as NOP.
    localparam logic [FuncWidth-1:0] FIRST_SPARE_OP = OP_NOP + 1'b1;
    localparam logic [FuncWidth-1:0] LAST_FUNC_CODE = '1;
    localparam int unsigned RUN_LIMIT     = 200000;
    localparam int unsigned REQS_PER_LOOP = 203;
    localparam int unsigned DRAIN_CYCLES  = 8;
    localparam int unsigned REPORT_MAX    = 10;

    // Shadow of the architectural registers plus the queue of outcomes still owed by the block.
    class cpu8_exec_shadow;
        logic [7:0]  acc;
        logic [7:0]  idx_x;
        logic [7:0]  idx_y;
        logic [7:0]  sp;
        logic [7:0]  flags;
        rsp_t        outcome_q[$];
        int unsigned failures;
        int unsigned reported;

        function new();
            acc      = '0;
            idx_x    = '0;
            idx_y    = '0;
            sp       = '0;
            flags    = '0;
            failures = 0;
            reported = 0;
        endfunction

        function void set_nz(logic [7:0] v);
            flags[FLAG_N] = v[7];
            flags[FLAG_Z] = (v == 8'h00);
        endfunction

        // Binary add with carry in; SBC comes here with the operand inverted.
        function void add_carry(logic [7:0] m);
            logic [8:0] sum;
            logic [7:0] r;
            logic [7:0] ovf;
            sum = {1'b0, acc} + {1'b0, m} + {8'h00, flags[FLAG_C]};
            r   = sum[7:0];
            ovf = (acc ^ r) & (m ^ r);
            flags[FLAG_C] = sum[8];
            flags[FLAG_V] = ovf[7];
            set_nz(r);
            acc = r;
        endfunction

        function void compare(logic [7:0] lhs, logic [7:0] m);
            flags[FLAG_C] = (lhs >= m);
            set_nz(lhs - m);
        endfunction

        // Rotates go through the carry held before the operation.
        function logic [7:0] shift_rotate(logic [FuncWidth-1:0] op, logic [7:0] v);
            logic       cin;
            logic [7:0] r;
            cin = flags[FLAG_C];
            case (op)
                OP_ASL: begin
                    flags[FLAG_C] = v[7];
                    r = {v[6:0], 1'b0};
                end
                OP_LSR: begin
                    flags[FLAG_C] = v[0];
                    r = {1'b0, v[7:1]};
                end
                OP_ROL: begin
                    flags[FLAG_C] = v[7];
                    r = {v[6:0], cin};
                end
                default: begin
                    flags[FLAG_C] = v[0];
                    r = {cin, v[7:1]};
                end
            endcase
            set_nz(r);
            return r;
        endfunction

        function rsp_t execute(req_t rq);
            rsp_t       o;
            logic [7:0] m;
            logic [7:0] r;
            o = '0;
            m = rq.operand;
            case (rq.func)
                OP_ADC: add_carry(m);
                OP_SBC: add_carry(~m);
                OP_AND: begin acc = acc & m; set_nz(acc); end
                OP_ORA: begin acc = acc | m; set_nz(acc); end
                OP_EOR: begin acc = acc ^ m; set_nz(acc); end
                OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
                    if (rq.on_accumulator) begin
                        acc = shift_rotate(rq.func, acc);
                    end else begin
                        o.write_data   = shift_rotate(rq.func, m);
                        o.write_enable = 1'b1;
                    end
                end
                OP_INC: begin
                    r = m + 8'h01;
                    set_nz(r);
                    o.write_enable = 1'b1;
                    o.write_data   = r;
                end
                OP_DEC: begin
                    r = m - 8'h01;
                    set_nz(r);
                    o.write_enable = 1'b1;
                    o.write_data   = r;
                end
                OP_INX: begin idx_x = idx_x + 8'h01; set_nz(idx_x); end
                OP_INY: begin idx_y = idx_y + 8'h01; set_nz(idx_y); end
                OP_DEX: begin idx_x = idx_x - 8'h01; set_nz(idx_x); end
                OP_DEY: begin idx_y = idx_y - 8'h01; set_nz(idx_y); end
                OP_CMP: compare(acc, m);
                OP_CPX: compare(idx_x, m);
                OP_CPY: compare(idx_y, m);
                OP_BIT: begin
                    flags[FLAG_Z] = ((acc & m) == 8'h00);
                    flags[FLAG_N] = m[7];
                    flags[FLAG_V] = m[6];
                end
                OP_LDA: begin acc = m; set_nz(m); end
                OP_LDX: begin idx_x = m; set_nz(m); end
                OP_LDY: begin idx_y = m; set_nz(m); end
                OP_STA: begin o.write_enable = 1'b1; o.write_data = acc; end
                OP_STX: begin o.write_enable = 1'b1; o.write_data = idx_x; end
                OP_STY: begin o.write_enable = 1'b1; o.write_data = idx_y; end
                OP_TAX: begin idx_x = acc; set_nz(idx_x); end
                OP_TAY: begin idx_y = acc; set_nz(idx_y); end
                OP_TXA: begin acc = idx_x; set_nz(acc); end
                OP_TYA: begin acc = idx_y; set_nz(acc); end
                OP_TSX: begin idx_x = sp; set_nz(idx_x); end
                OP_TXS: sp = idx_x;
                OP_CLC: flags[FLAG_C] = 1'b0;
                OP_CLD: flags[FLAG_D] = 1'b0;
                OP_CLI: flags[FLAG_I] = 1'b0;
                OP_CLV: flags[FLAG_V] = 1'b0;
                OP_SEC: flags[FLAG_C] = 1'b1;
                OP_SED: flags[FLAG_D] = 1'b1;
                OP_SEI: flags[FLAG_I] = 1'b1;
                OP_BCC: o.branch_taken = !flags[FLAG_C];
                OP_BCS: o.branch_taken = flags[FLAG_C];
                OP_BEQ: o.branch_taken = flags[FLAG_Z];
                OP_BMI: o.branch_taken = flags[FLAG_N];
                OP_BNE: o.branch_taken = !flags[FLAG_Z];
                OP_BPL: o.branch_taken = !flags[FLAG_N];
                OP_BVC: o.branch_taken = !flags[FLAG_V];
                OP_BVS: o.branch_taken = flags[FLAG_V];
                default: ;
            endcase
            o.status_out = flags;
            return o;
        endfunction

        function void note_request(req_t rq);
            outcome_q.push_back(execute(rq));
        endfunction

        function void check_result(rsp_t got);
            rsp_t want;
            if (outcome_q.size() == 0) begin
                failures++;
                reported++;
                if (reported <= REPORT_MAX)
                    $display("ERROR: unexpected result we=%b wd=%h br=%b st=%h",
                             got.write_enable, got.write_data, got.branch_taken, got.status_out);
                return;
            end
            want = outcome_q.pop_front();
            if (got.write_enable !== want.write_enable || got.write_data !== want.write_data ||
                got.branch_taken !== want.branch_taken || got.status_out !== want.status_out) begin
                failures++;
                reported++;
                if (reported <= REPORT_MAX)
                    $display("ERROR: exp we=%b wd=%h br=%b st=%h got we=%b wd=%h br=%b st=%h",
                             want.write_enable, want.write_data, want.branch_taken,
                             want.status_out, got.write_enable, got.write_data,
                             got.branch_taken, got.status_out);
            end
        endfunction
    endclass

    logic aclk;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    req_t s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    rsp_t m_data;

    int unsigned src_idle_pct  = 0;
    int unsigned sink_stall_pct = 0;

    cpu8_exec_shadow shadow;

    cpu8_alu_register_flags dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop: a run that hangs is reported as failed and ended.
    initial begin
        repeat (RUN_LIMIT) @(posedge aclk);
        $display("Some tests failed");
        $finish;
    end

    // Result side: check every accepted result, then roll the stall for the next cycle.
    // Sampling at the edge sees pre-edge values, since the block updates with nonblocking writes.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            shadow.check_result(m_data);
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    function automatic req_t make_request(logic [FuncWidth-1:0] op, logic [7:0] m, logic on_acc);
        req_t r;
        r.func           = op;
        r.operand        = m;
        r.on_accumulator = on_acc;
        return r;
    endfunction

    function automatic logic [7:0] corner_byte(int unsigned sel);
        case (sel % 4)
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            default: return 8'h7F;
        endcase
    endfunction

    // Mostly defined operations, some spare codes; operands lean on the byte corners now and then.
    function automatic req_t random_request();
        req_t r;
        if ($urandom_range(99) < 92)
            r.func = FuncWidth'($urandom_range(OP_NOP, OP_ADC));
        else
            r.func = FuncWidth'($urandom_range(LAST_FUNC_CODE, FIRST_SPARE_OP));
        if ($urandom_range(4) == 0)
            r.operand = corner_byte($urandom_range(3));
        else
            r.operand = 8'($urandom_range(255));
        r.on_accumulator = 1'($urandom_range(1));
        return r;
    endfunction

    // Offer one request and hold it until the block takes it.
    // Valid stays high across back-to-back requests; drop it only for an idle cycle.
    task automatic send_request(req_t rq);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= rq;
        do @(posedge aclk); while (!s_ready);
        shadow.note_request(rq);
    endtask

    initial begin
        shadow = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Signed overflow both ways, carry out, and borrow on SBC.
        send_request(make_request(OP_LDA, 8'h00, 1'b0));
        send_request(make_request(OP_LDA, 8'h7F, 1'b0));
        send_request(make_request(OP_CLC, 8'h00, 1'b0));
        send_request(make_request(OP_ADC, 8'h01, 1'b0));
        send_request(make_request(OP_ADC, 8'hFF, 1'b0));
        send_request(make_request(OP_SEC, 8'h00, 1'b0));
        send_request(make_request(OP_SBC, 8'h80, 1'b0));
        send_request(make_request(OP_SBC, 8'hFF, 1'b1));
        // Compare: equal and below; then BIT sets V for a taken BVS.
        send_request(make_request(OP_LDA, 8'h40, 1'b0));
        send_request(make_request(OP_CMP, 8'h40, 1'b0));
        send_request(make_request(OP_CMP, 8'hFF, 1'b0));
        send_request(make_request(OP_BIT, 8'hC0, 1'b0));
        send_request(make_request(OP_BVS, 8'h00, 1'b0));
        // ROL on A through an old carry of one, then ROR on memory; LSR must clear N.
        send_request(make_request(OP_SEC, 8'h00, 1'b0));
        send_request(make_request(OP_ROL, 8'h00, 1'b1));
        send_request(make_request(OP_ROR, 8'h01, 1'b0));
        send_request(make_request(OP_LDA, 8'hFF, 1'b0));
        send_request(make_request(OP_LSR, 8'h00, 1'b1));
        // Memory read-modify-write wraps, a store, SP round trip, spare code and flag ignored.
        send_request(make_request(OP_INC, 8'hFF, 1'b1));
        send_request(make_request(OP_DEC, 8'h00, 1'b0));
        send_request(make_request(OP_DEX, 8'h00, 1'b0));
        send_request(make_request(OP_TXS, 8'h00, 1'b0));
        send_request(make_request(OP_TSX, 8'h00, 1'b0));
        send_request(make_request(OP_STX, 8'h00, 1'b1));
        send_request(make_request(LAST_FUNC_CODE, 8'hFF, 1'b1));

        // Sweep every function code once, spare ones included.
        for (int unsigned code = 0; code <= LAST_FUNC_CODE; code++)
            send_request(make_request(FuncWidth'(code), corner_byte(code), code[0]));

        // Random traffic under four idle/stall mixes.
        for (int unsigned loop_idx = 0; loop_idx < 4; loop_idx++) begin
            case (loop_idx)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 61; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 61; end
                default: begin src_idle_pct = 36; sink_stall_pct = 36; end
            endcase
            repeat (REQS_PER_LOOP) send_request(random_request());
        end
        s_valid <= 1'b0;

        // Drain the results still owed, then let the pipe settle before the final check.
        while (shadow.outcome_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (shadow.failures == 0 && shadow.outcome_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
